>>> rtl/xrg_pkg.sv
// Package for the xoshiro128 ranged generator.
// Transaction types, operation codes, seed reset values and sizes.
// No dependencies.
package xrg_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned SEED_COUNT = 4;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned EXTRA_W    = 8;
	localparam int unsigned DIV_STEPS  = DATA_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [EXTRA_W-1:0] MAX_EXTRA = 8'd255;
	localparam logic [DATA_W-1:0]  SEED0_RST = 32'd1;
	localparam logic [DATA_W-1:0]  SEEDN_RST = 32'd0;

	typedef enum logic [1:0] {
		OP_STARSTAR = 2'd0,
		OP_PLUS     = 2'd1,
		OP_RANGED   = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [DATA_W-1:0] range_min;
		logic [DATA_W-1:0] range_max;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  value;
		logic [EXTRA_W-1:0] extra_draws;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;     // latch request, compute range
		logic div_start;    // start divider
		logic div_sel_quot; // 1: draw word / scale, 0: all ones / range
		logic load_limit;   // capture scale and range*scale
		logic draw;         // advance state, capture output word
		logic count_extra;  // rejected draw
		logic out_load;     // load response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic range_zero;
		logic div_done;
		logic reject;
	} sts_t;

endpackage

>>> rtl/xrg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on xrg_pkg.
module xrg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [xrg_pkg::DATA_W-1:0] num,
	input  logic [xrg_pkg::DATA_W-1:0] den,
	output logic                      done,
	output logic [xrg_pkg::DATA_W-1:0] quot
);

	logic                          busy_q;
	logic [xrg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [xrg_pkg::DATA_W-1:0]    rem_q;
	logic [xrg_pkg::DATA_W-1:0]    quo_q;
	logic [xrg_pkg::DATA_W-1:0]    den_q;
	logic [xrg_pkg::DATA_W:0]      shifted;
	logic [xrg_pkg::DATA_W:0]      diff;
	logic                          ge;

	localparam logic [xrg_pkg::DIV_CNT_W-1:0] LAST =
		xrg_pkg::DIV_CNT_W'(xrg_pkg::DIV_STEPS - 1);

	always_comb begin
		shifted = {rem_q, quo_q[xrg_pkg::DATA_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[xrg_pkg::DATA_W-1:0] : shifted[xrg_pkg::DATA_W-1:0];
			quo_q <= {quo_q[xrg_pkg::DATA_W-2:0], ge};
		end
	end

	// last step completes at this edge
	assign done = busy_q && (cnt_q == LAST);
	assign quot = quo_q;

endmodule

>>> rtl/xrg_datapath.sv
// Datapath: seed registers, generator state, output words, range math.
// Depends on xrg_pkg and xrg_div.
module xrg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [xrg_pkg::ADDR_W-1:0] paddr,
	input  logic [xrg_pkg::DATA_W-1:0] pwdata,
	output logic [xrg_pkg::DATA_W-1:0] prdata,
	input  xrg_pkg::req_t              req,
	input  xrg_pkg::cmd_t              cmd,
	output xrg_pkg::sts_t              sts,
	output xrg_pkg::rsp_t              rsp
);

	logic [xrg_pkg::DATA_W-1:0] seed_q [xrg_pkg::SEED_COUNT];
	logic [xrg_pkg::DATA_W-1:0] st_q   [xrg_pkg::SEED_COUNT];
	logic [xrg_pkg::DATA_W-1:0] st_nxt [xrg_pkg::SEED_COUNT];

	xrg_pkg::op_t               op_q;
	logic [xrg_pkg::DATA_W-1:0] lo_q;
	logic [xrg_pkg::DATA_W-1:0] range_q;
	logic [xrg_pkg::DATA_W-1:0] scale_q;
	logic [xrg_pkg::DATA_W-1:0] limit_q;
	logic [xrg_pkg::DATA_W-1:0] w_q;
	logic [xrg_pkg::EXTRA_W-1:0] extra_q;
	xrg_pkg::rsp_t              rsp_q;

	logic                         cfg_wr;
	logic [1:0]                   cfg_idx;
	logic [xrg_pkg::DATA_W-1:0]   mul5;
	logic [xrg_pkg::DATA_W-1:0]   rot;
	logic [xrg_pkg::DATA_W-1:0]   ss_word;
	logic [xrg_pkg::DATA_W-1:0]   plus_word;
	logic [xrg_pkg::DATA_W-1:0]   t9;
	logic [2*xrg_pkg::DATA_W-1:0] prod;
	logic [xrg_pkg::DATA_W-1:0]   div_num;
	logic [xrg_pkg::DATA_W-1:0]   div_den;
	logic [xrg_pkg::DATA_W-1:0]   div_quot;
	logic                         div_done;
	logic [xrg_pkg::DATA_W-1:0]   result;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];
	assign prdata  = seed_q[cfg_idx];

	// star-star: rotl(s1*5, 7)*9 as shift-adds; plus: s0+s3
	always_comb begin
		mul5      = st_q[1] + {st_q[1][xrg_pkg::DATA_W-3:0], 2'b00};
		rot       = {mul5[xrg_pkg::DATA_W-8:0], mul5[xrg_pkg::DATA_W-1:xrg_pkg::DATA_W-7]};
		ss_word   = rot + {rot[xrg_pkg::DATA_W-4:0], 3'b000};
		plus_word = st_q[0] + st_q[3];
	end

	// one xoshiro128 step
	always_comb begin
		t9        = {st_q[1][xrg_pkg::DATA_W-10:0], 9'd0};
		st_nxt[2] = st_q[2] ^ st_q[0];
		st_nxt[3] = st_q[3] ^ st_q[1];
		st_nxt[1] = st_q[1] ^ st_nxt[2];
		st_nxt[0] = st_q[0] ^ st_nxt[3];
		st_nxt[2] = st_nxt[2] ^ t9;
		st_nxt[3] = {st_nxt[3][xrg_pkg::DATA_W-12:0], st_nxt[3][xrg_pkg::DATA_W-1:xrg_pkg::DATA_W-11]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < xrg_pkg::SEED_COUNT; i++) begin
				seed_q[i] <= (i == 0) ? xrg_pkg::SEED0_RST : xrg_pkg::SEEDN_RST;
				st_q[i]   <= (i == 0) ? xrg_pkg::SEED0_RST : xrg_pkg::SEEDN_RST;
			end
		end else if (cfg_wr) begin
			// any seed write reloads the whole state
			for (int i = 0; i < xrg_pkg::SEED_COUNT; i++) begin
				if (cfg_idx == 2'(i)) begin
					seed_q[i] <= pwdata;
					st_q[i]   <= pwdata;
				end else begin
					st_q[i] <= seed_q[i];
				end
			end
		end else if (cmd.draw) begin
			for (int i = 0; i < xrg_pkg::SEED_COUNT; i++) begin
				st_q[i] <= st_nxt[i];
			end
		end
	end

	assign div_num = cmd.div_sel_quot ? ss_word : '1;
	assign div_den = cmd.div_sel_quot ? scale_q : range_q;

	xrg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign prod = {{xrg_pkg::DATA_W{1'b0}}, range_q} * {{xrg_pkg::DATA_W{1'b0}}, div_quot};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= xrg_pkg::op_t'(req.operation);
			lo_q    <= req.range_min;
			range_q <= req.range_max - req.range_min + 1'b1;
		end
		if (cmd.load_limit) begin
			scale_q <= div_quot;
			limit_q <= prod[xrg_pkg::DATA_W-1:0];
		end
		if (cmd.draw) begin
			w_q <= (op_q == xrg_pkg::OP_PLUS) ? plus_word : ss_word;
		end
		if (cmd.out_load) begin
			rsp_q.value       <= result;
			rsp_q.extra_draws <= extra_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_q <= '0;
		end else if (cmd.load_req) begin
			extra_q <= '0;
		end else if (cmd.count_extra && (extra_q != xrg_pkg::MAX_EXTRA)) begin
			extra_q <= extra_q + 1'b1;
		end
	end

	always_comb begin
		unique case (op_q)
			xrg_pkg::OP_STARSTAR,
			xrg_pkg::OP_PLUS:   result = w_q;
			xrg_pkg::OP_RANGED: result = ((range_q == '0) ? w_q : div_quot) + lo_q;
			default:            result = '0;
		endcase
	end

	assign sts.op         = op_q;
	assign sts.range_zero = (range_q == '0);
	assign sts.div_done   = div_done;
	assign sts.reject     = (ss_word >= limit_q);
	assign rsp            = rsp_q;

endmodule

>>> rtl/xrg_ctrl.sv
// Controller state machine and response handshake.
// Depends on xrg_pkg.
module xrg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  xrg_pkg::sts_t sts,
	output xrg_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DISPATCH = 6'b000010,
		ST_SCALE    = 6'b000100,
		ST_LIMIT    = 6'b001000,
		ST_DRAW     = 6'b010000,
		ST_QUOT     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   done_q;
	logic   done_d;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		done_d  = done_q;
		cmd     = '0;
		// result waiting for the output register
		if (done_q && slot_free) begin
			cmd.out_load = 1'b1;
			done_d       = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && !done_q) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if ((sts.op == xrg_pkg::OP_RANGED) && !sts.range_zero) begin
					cmd.div_start = 1'b1;
					state_d       = ST_SCALE;
				end else begin
					cmd.draw = (sts.op != xrg_pkg::OP_NONE);
					done_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SCALE: begin
				if (sts.div_done) begin
					state_d = ST_LIMIT;
				end
			end
			ST_LIMIT: begin
				cmd.load_limit = 1'b1;
				state_d        = ST_DRAW;
			end
			ST_DRAW: begin
				cmd.draw = 1'b1;
				if (sts.reject) begin
					cmd.count_extra = 1'b1;
				end else begin
					cmd.div_start    = 1'b1;
					cmd.div_sel_quot = 1'b1;
					state_d          = ST_QUOT;
				end
			end
			ST_QUOT: begin
				if (sts.div_done) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE) && !done_q;
	assign rsp_valid = rsp_valid_q;

endmodule

>>> rtl/xoshiro128_ranged_generator.sv
// Operations 0, 1, 3 and full-span ranged requests need no divider pass; any other
// ranged request also draws once more per rejected word, and two passes of the shared
// bit-serial divider dominate its time.
// Throughput: one request at a time; the next request is taken once the result has
// moved to the response register. Reset (arst_n low, asynchronous) sets the seeds to
// 1, 0, 0, 0, loads the state from them and empties the response register.
// Top level of the xoshiro128 ranged generator: controller, datapath, APB seed port.
// Depends on xrg_pkg, xrg_ctrl, xrg_datapath (and xrg_div below it).
module xoshiro128_ranged_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB seed registers; pready is tied high
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [xrg_pkg::ADDR_W-1:0] paddr,
	input  logic [xrg_pkg::DATA_W-1:0] pwdata,
	output logic [xrg_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	// request transactions
	input  logic                       req_valid,
	output logic                       req_ready,
	input  xrg_pkg::req_t              req,
	// response transactions
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output xrg_pkg::rsp_t              rsp
);

	xrg_pkg::cmd_t cmd;
	xrg_pkg::sts_t sts;

	assign pready = 1'b1;

	// Sequencer: dispatch on operation; ranged path with a nonzero span is
	// scale = ~0 / range, limit = range * scale, draw until word < limit,
	// then word / scale + min.
	xrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// State, seeds, output mixers, divider, multiplier, response register.
	xrg_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.req     (req),
		.cmd     (cmd),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

>>> rtl/xrg_checker.sv
// Port-level checks for the xoshiro128 ranged generator, bound to the top level.
// Depends on xrg_pkg and xoshiro128_ranged_generator.
module xrg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input xrg_pkg::rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// no response can appear the cycle after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("response too early");

endmodule

bind xoshiro128_ranged_generator xrg_checker u_xrg_checker (.*);

>>> bench/tb_xoshiro128_ranged_generator.sv
// Self-checking testbench for xoshiro128_ranged_generator: seed port, request and response
// transactions, checked against an in-bench xoshiro128 predictor held by a scoreboard class.
// Depends on xrg_pkg and the generator RTL.
module tb_xoshiro128_ranged_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import xrg_pkg::*;

	localparam int unsigned CLK_HALF      = 5;
	localparam int unsigned RESET_CYCLES  = 9;
	localparam int unsigned QUIET_LIMIT   = 5000; // watchdog limit on cycles with no transaction
	localparam int unsigned SETTLE_CYCLES = 8;    // longer than the short-op latency
	localparam int unsigned REG_STRIDE    = 4;

	// seed register indexes
	typedef enum int unsigned {
		SEED_WORD0 = 0,
		SEED_WORD1 = 1,
		SEED_WORD2 = 2,
		SEED_WORD3 = 3
	} seed_reg_e;

	// shapes of the [min,max] window used for ranged requests
	typedef enum int unsigned {
		SHAPE_NARROW,
		SHAPE_HALF_PLUS, // span just over 2^31: scale 1, about half the draws rejected
		SHAPE_ANY,
		SHAPE_FULL,      // max = min - 1, span wraps to zero
		SHAPE_SINGLE,
		SHAPE_POW2
	} range_shape_e;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Mirrors the seed registers and the generator state; keeps the queue of
	// responses still owed by the block.
	class seed_stream_scoreboard;
		logic [DATA_W-1:0] seed_reg [SEED_COUNT];
		logic [DATA_W-1:0] gen [SEED_COUNT];
		rsp_t awaited_rsp [$];
		int unsigned errors;
		int unsigned responses;
		int unsigned seed_writes;
		int unsigned rejected_total;
		int unsigned max_extra;
		int unsigned op_seen [4];

		function void reload();
			foreach (gen[i]) gen[i] = seed_reg[i];
		endfunction

		function void reset_seeds();
			seed_reg[SEED_WORD0] = SEED0_RST;
			for (int unsigned i = 1; i < SEED_COUNT; i++) seed_reg[i] = SEEDN_RST;
			reload();
		endfunction

		// any seed write reloads the whole state
		function void write_seed(input int unsigned idx, input logic [DATA_W-1:0] word);
			if (idx < SEED_COUNT) begin
				seed_reg[idx] = word;
				reload();
			end
			seed_writes++;
		endfunction

		function logic [DATA_W-1:0] rotl(input logic [DATA_W-1:0] x, input int unsigned k);
			return (x << k) | (x >> (DATA_W - k));
		endfunction

		function void advance_state();
			logic [DATA_W-1:0] t;
			t = gen[1] << 9;
			gen[2] ^= gen[0];
			gen[3] ^= gen[1];
			gen[1] ^= gen[2];
			gen[0] ^= gen[3];
			gen[2] ^= t;
			gen[3] = rotl(gen[3], 11);
		endfunction

		function logic [DATA_W-1:0] draw_starstar();
			logic [DATA_W-1:0] word;
			word = rotl(gen[1] * 32'd5, 7) * 32'd9;
			advance_state();
			return word;
		endfunction

		// predict the response of one accepted request and queue it
		function void note_request(input req_t r);
			rsp_t exp_rsp;
			logic [DATA_W-1:0] span;
			logic [DATA_W-1:0] scale;
			logic [DATA_W-1:0] limit;
			logic [DATA_W-1:0] word;
			exp_rsp = '0;
			case (op_t'(r.operation))
				OP_STARSTAR: exp_rsp.value = draw_starstar();
				OP_PLUS: begin
					exp_rsp.value = gen[0] + gen[3];
					advance_state();
				end
				OP_RANGED: begin
					span = r.range_max - r.range_min + 32'd1;
					if (span == '0) begin
						exp_rsp.value = draw_starstar() + r.range_min;
					end else begin
						scale = {DATA_W{1'b1}} / span;
						limit = span * scale;
						word = draw_starstar();
						while (word >= limit) begin
							if (exp_rsp.extra_draws < MAX_EXTRA) exp_rsp.extra_draws++;
							rejected_total++;
							word = draw_starstar();
						end
						exp_rsp.value = word / scale + r.range_min;
					end
					if (exp_rsp.extra_draws > max_extra) max_extra = exp_rsp.extra_draws;
				end
				default: ; // unused op: state untouched, zero response
			endcase
			awaited_rsp.push_back(exp_rsp);
			op_seen[r.operation]++;
		endfunction

		function void check_response(input rsp_t got);
			rsp_t exp_rsp;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: response with none outstanding: value %h extra_draws %0d",
					$time, got.value, got.extra_draws);
				errors++;
				return;
			end
			exp_rsp = awaited_rsp.pop_front();
			responses++;
			if (got.value !== exp_rsp.value) begin
				$display("%0t: value mismatch: expected %h actual %h",
					$time, exp_rsp.value, got.value);
				errors++;
			end
			if (got.extra_draws !== exp_rsp.extra_draws) begin
				$display("%0t: extra_draws mismatch: expected %0d actual %0d",
					$time, exp_rsp.extra_draws, got.extra_draws);
				errors++;
			end
		endfunction

		function void check_seed(input int unsigned idx, input logic [DATA_W-1:0] got);
			if (got !== seed_reg[idx]) begin
				$display("%0t: seed %0d readback: expected %h actual %h",
					$time, idx, seed_reg[idx], got);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction
	endclass

	seed_stream_scoreboard sb = new();

	int unsigned burst_left = 0;
	int unsigned ready_run = 0;
	int unsigned quiet_cycles = 0;

	xoshiro128_ranged_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #(CLK_HALF) clk = ~clk;

	// Receiver: long open stretches mixed with short ready bursts and stalls, independent
	// of the sender so stalls can land on any phase of a request.
	always @(posedge clk) begin
		if (ready_run == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					rsp_ready <= 1'b1;
					ready_run <= $urandom_range(50, 300);
				end
				1: begin
					rsp_ready <= 1'b0;
					ready_run <= $urandom_range(1, 20);
				end
				default: begin
					rsp_ready <= 1'b1;
					ready_run <= $urandom_range(1, 8);
				end
			endcase
		end else begin
			ready_run <= ready_run - 1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_response(rsp);
	end

	// Watchdog: any transaction (request, response or APB access) restarts the count.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d responses outstanding",
				$time, QUIET_LIMIT, sb.pending());
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One APB access: setup cycle, access cycle(s) until pready, then psel is lowered and held
	// low before returning, so a following access never re-raises psel in the step that lowered it.
	task automatic apb_access(input logic write, input int unsigned idx,
			input logic [DATA_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= ADDR_W'(idx * REG_STRIDE);
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (write) sb.write_seed(idx, word);
		else sb.check_seed(idx, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Sender holds off until every outstanding response is in and the block has settled.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Seeds are only rewritten with the block idle; each is read back afterwards.
	task automatic load_seeds(input logic [DATA_W-1:0] words [SEED_COUNT]);
		drain();
		for (int unsigned i = 0; i < SEED_COUNT; i++) apb_access(1'b1, i, words[i]);
		for (int unsigned i = 0; i < SEED_COUNT; i++) apb_access(1'b0, i, '0);
	endtask

	// valid stays up, payload fixed, until the handshake
	task automatic send_request(input req_t r);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	// Bursty sender: short or long bursts of requests with req_valid low between them.
	task automatic issue(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		send_request(r);
	endtask

	function automatic req_t make_request();
		req_t r;
		int unsigned pick;
		r.range_min = $urandom;
		r.range_max = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r.operation = OP_STARSTAR;
		end else if (pick < 50) begin
			r.operation = OP_PLUS;
		end else if (pick < 92) begin
			r.operation = OP_RANGED;
			case (range_shape_e'($urandom_range(SHAPE_NARROW, SHAPE_POW2)))
				SHAPE_NARROW:    r.range_max = r.range_min + $urandom_range(0, 1000);
				SHAPE_HALF_PLUS: r.range_max = r.range_min + 32'h8000_0000
					+ $urandom_range(0, 255);
				SHAPE_FULL:      r.range_max = r.range_min - 32'd1;
				SHAPE_SINGLE:    r.range_max = r.range_min;
				SHAPE_POW2:      r.range_max = r.range_min
					+ (32'd1 << $urandom_range(0, 31)) - 32'd1;
				default: ;
			endcase
		end else begin
			r.operation = OP_NONE;
		end
		return r;
	endfunction

	task automatic run_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) == 0) drain();
			issue(make_request());
		end
	endtask

	// Field extremes, every op, both full-span forms, single-value and reversed windows,
	// and windows with heavy rejection.
	task automatic directed_requests();
		issue('{OP_STARSTAR, 32'h0000_0000, 32'h0000_0000});
		issue('{OP_PLUS,     32'hFFFF_FFFF, 32'hFFFF_FFFF});
		issue('{OP_NONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF});
		issue('{OP_RANGED,   32'h0000_0000, 32'hFFFF_FFFF}); // full span
		issue('{OP_RANGED,   32'd5,         32'd4});         // wraps to full span
		issue('{OP_RANGED,   32'h0000_0000, 32'h0000_0000});
		issue('{OP_RANGED,   32'hFFFF_FFFF, 32'hFFFF_FFFF});
		issue('{OP_RANGED,   32'd0,         32'd1});
		issue('{OP_RANGED,   32'd0,         32'd9});
		issue('{OP_RANGED,   32'd1000,      32'd10});        // reversed bounds
		issue('{OP_RANGED,   32'hFFFF_FFF0, 32'h0000_000F}); // window across the top
		issue('{OP_RANGED,   32'h0000_0000, 32'h8000_0000});
		issue('{OP_RANGED,   32'h7FFF_FFFF, 32'hFFFF_FFFF});
		issue('{OP_RANGED,   32'h0000_0000, 32'h7FFF_FFFF});
		issue('{OP_RANGED,   32'h0000_0000, 32'hFFFF_FFFE});
		issue('{OP_RANGED,   32'h1234_5678, 32'h1234_56DB});
		issue('{OP_STARSTAR, 32'hFFFF_FFFF, 32'h0000_0000});
		issue('{OP_PLUS,     32'h0000_0000, 32'hFFFF_FFFF});
		issue('{OP_STARSTAR, 32'hA5A5_A5A5, 32'h5A5A_5A5A});
	endtask

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		sb.reset_seeds();
		@(posedge clk);

		// reset seeds (1,0,0,0)
		directed_requests();
		run_random(420);

		// arbitrary seeds
		load_seeds('{$urandom, $urandom, $urandom, $urandom});
		run_random(420);

		// all-zero state: every draw is zero, ranged requests accept at once
		load_seeds('{32'h0, 32'h0, 32'h0, 32'h0});
		issue('{OP_RANGED, 32'h0000_0000, 32'hFFFF_FFFF});
		issue('{OP_RANGED, 32'd3, 32'd9});
		issue('{OP_PLUS, 32'h0, 32'h0});
		run_random(60);

		// all-ones seeds
		load_seeds('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		run_random(400);

		// single register write mid-run reloads the state from all four seeds
		drain();
		apb_access(1'b1, SEED_WORD2, $urandom);
		apb_access(1'b0, SEED_WORD2, '0);
		run_random(300);

		drain();
		$display("%0d responses checked: %0d star-star, %0d plus, %0d ranged, %0d unused op",
			sb.responses, sb.op_seen[OP_STARSTAR], sb.op_seen[OP_PLUS],
			sb.op_seen[OP_RANGED], sb.op_seen[OP_NONE]);
		$display("%0d seed writes; %0d rejected draws, at most %0d in one ranged request",
			sb.seed_writes, sb.rejected_total, sb.max_extra);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/xrg_pkg.sv
rtl/xrg_div.sv
rtl/xrg_datapath.sv
rtl/xrg_ctrl.sv
rtl/xoshiro128_ranged_generator.sv
rtl/xrg_checker.sv
bench/tb_xoshiro128_ranged_generator.sv
